// ===== sv/stl_pkg.sv =====
package stl_pkg;

    localparam int INTERP_DEPTH  = 16;
    localparam int POSITION_BITS = 24;
    localparam int TOP_W         = $clog2(INTERP_DEPTH + 1);
    localparam int IDX_W         = (INTERP_DEPTH > 1) ? $clog2(INTERP_DEPTH) : 1;
    localparam int RES_MAX       = 3;
    localparam int FIELD_W       = 3 + 3 * POSITION_BITS + 64;
    localparam int DATA_W        = ((FIELD_W + 7) / 8) * 8;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    localparam logic [6:0] KIND_END    = 7'd0;
    localparam logic [6:0] KIND_INT    = 7'd1;
    localparam logic [6:0] KIND_STR    = 7'd2;
    localparam logic [6:0] KIND_HEAD   = 7'd3;
    localparam logic [6:0] KIND_MID    = 7'd4;
    localparam logic [6:0] KIND_TAIL   = 7'd5;
    localparam logic [6:0] KIND_ICLOSE = 7'd6;
    localparam logic [6:0] KIND_IDENT  = 7'd7;
    localparam logic [6:0] KIND_AUSER  = 7'd31;
    localparam logic [6:0] KIND_ACAPS  = 7'd32;
    localparam logic [6:0] KIND_ADROP  = 7'd33;
    localparam logic [6:0] KIND_LBRACE = 7'd39;
    localparam logic [6:0] KIND_RBRACE = 7'd40;
    localparam logic [6:0] KIND_BYTE   = 7'd70;
    localparam logic [6:0] KIND_ERROR  = 7'd71;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_OPEN_STR  = 3'd1;
    localparam logic [2:0] ERR_ESCAPE    = 3'd2;
    localparam logic [2:0] ERR_DEEP      = 3'd3;
    localparam logic [2:0] ERR_ATTR      = 3'd4;
    localparam logic [2:0] ERR_DROP      = 3'd5;
    localparam logic [2:0] ERR_CHAR      = 3'd6;
    localparam logic [2:0] ERR_OPEN_INTP = 3'd7;

    localparam logic [47:0]  ATTR_USER = "[user]";
    localparam logic [119:0] ATTR_CAPS = "[caps(syscall)]";
    localparam logic [47:0]  ATTR_DROP = "[drop(";

    typedef struct packed {
        logic [6:0]               kind;
        logic [2:0]               err;
        logic [POSITION_BITS-1:0] line;
        logic [POSITION_BITS-1:0] span_s;
        logic [POSITION_BITS-1:0] span_e;
        logic signed [63:0]       value;
    } t_res;

    typedef struct packed {
        logic [1:0]             cnt;
        t_res [RES_MAX-1:0]     res;
    } t_grp;

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] x);
        return (x == POS_MAX) ? x : x + 1'b1;
    endfunction

    function automatic t_res mk_res(input logic [6:0] kind, input logic [2:0] err,
                                    input logic [POSITION_BITS-1:0] line,
                                    input logic [POSITION_BITS-1:0] s,
                                    input logic [POSITION_BITS-1:0] e,
                                    input logic [63:0] val);
        t_res r;
        r.kind   = kind;
        r.err    = err;
        r.line   = line;
        r.span_s = s;
        r.span_e = e;
        r.value  = val;
        return r;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_hexd(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        t = is_digit(c) ? c - "0" : (c | 8'h20) - "a" + 8'd10;
        return t[3:0];
    endfunction

    function automatic logic [6:0] word_kind(input logic [63:0] p, input logic [3:0] n);
        logic [6:0] k;
        k = KIND_IDENT;
        case ({n, p})
            {4'd6, 64'("extern")}:   k = 7'd8;
            {4'd7, 64'("syscall")}:  k = 7'd9;
            {4'd2, 64'("fn")}:       k = 7'd10;
            {4'd3, 64'("mut")}:      k = 7'd11;
            {4'd6, 64'("return")}:   k = 7'd12;
            {4'd2, 64'("if")}:       k = 7'd13;
            {4'd4, 64'("else")}:     k = 7'd14;
            {4'd5, 64'("while")}:    k = 7'd15;
            {4'd5, 64'("break")}:    k = 7'd16;
            {4'd8, 64'("continue")}: k = 7'd17;
            {4'd2, 64'("as")}:       k = 7'd18;
            {4'd3, 64'("raw")}:      k = 7'd19;
            {4'd4, 64'("true")}:     k = 7'd20;
            {4'd5, 64'("false")}:    k = 7'd21;
            {4'd6, 64'("struct")}:   k = 7'd22;
            {4'd5, 64'("defer")}:    k = 7'd23;
            {4'd4, 64'("enum")}:     k = 7'd24;
            {4'd5, 64'("match")}:    k = 7'd25;
            {4'd4, 64'("impl")}:     k = 7'd27;
            {4'd3, 64'("for")}:      k = 7'd28;
            {4'd2, 64'("in")}:       k = 7'd29;
            {4'd3, 64'("own")}:      k = 7'd36;
            default:                 k = KIND_IDENT;
        endcase
        return k;
    endfunction

    function automatic logic [6:0] single_kind(input logic [7:0] c);
        logic [6:0] k;
        case (c)
            "(":     k = 7'd37;
            ")":     k = 7'd38;
            ",":     k = 7'd41;
            ";":     k = 7'd42;
            "[":     k = 7'd34;
            "]":     k = 7'd35;
            "?":     k = 7'd69;
            "^":     k = 7'd65;
            "%":     k = 7'd51;
            "*":     k = 7'd49;
            "/":     k = 7'd50;
            ".":     k = 7'd68;
            ":":     k = 7'd43;
            "-":     k = 7'd48;
            "+":     k = 7'd47;
            "=":     k = 7'd46;
            "!":     k = 7'd60;
            "<":     k = 7'd56;
            ">":     k = 7'd58;
            "&":     k = 7'd63;
            "|":     k = 7'd64;
            default: k = KIND_END;
        endcase
        return k;
    endfunction

    function automatic logic is_pair_first(input logic [7:0] c);
        return c == "." || c == ":" || c == "-" || c == "+" || c == "=" || c == "!" ||
               c == "<" || c == ">" || c == "&" || c == "|" || c == "/";
    endfunction

    // Returns a valid flag above the kind of the two-byte operator.
    function automatic logic [7:0] pair_kind(input logic [7:0] f, input logic [7:0] c);
        logic [7:0] r;
        r = 8'd0;
        case (f)
            ".": if (c == ".") r = {1'b1, 7'd30};
            ":": if (c == "=") r = {1'b1, 7'd44};
            "-": if (c == ">") r = {1'b1, 7'd45}; else if (c == "=") r = {1'b1, 7'd53};
            "+": if (c == "=") r = {1'b1, 7'd52};
            "=": if (c == "=") r = {1'b1, 7'd54}; else if (c == ">") r = {1'b1, 7'd26};
            "!": if (c == "=") r = {1'b1, 7'd55};
            "<": if (c == "=") r = {1'b1, 7'd57}; else if (c == "<") r = {1'b1, 7'd66};
            ">": if (c == "=") r = {1'b1, 7'd59}; else if (c == ">") r = {1'b1, 7'd67};
            "&": if (c == "&") r = {1'b1, 7'd61};
            "|": if (c == "|") r = {1'b1, 7'd62};
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    // Returns a valid flag above the decoded byte.
    function automatic logic [8:0] escape_val(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            "n":     r = {1'b1, 8'd10};
            "t":     r = {1'b1, 8'd9};
            "r":     r = {1'b1, 8'd13};
            "0":     r = {1'b1, 8'd0};
            "\\", "\"", "'", "{", "}": r = {1'b1, c};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/stl_out_buf.sv =====
module stl_out_buf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  stl_pkg::t_grp i_grp,
    output logic          o_ready,
    output logic          o_tvalid,
    input  logic          i_tready,
    output stl_pkg::t_res o_res,
    output logic          o_last
);

    stl_pkg::t_res [stl_pkg::RES_MAX-1:0] r_grp;
    stl_pkg::t_res                        r_out;
    logic [1:0]                           r_gcnt;
    logic [1:0]                           r_gidx;
    logic                                 r_ovalid;
    logic                                 r_olast;
    logic                                 move;

    assign move    = (r_gcnt != 2'd0) && (!r_ovalid || i_tready);
    assign o_ready = (r_gcnt == 2'd0) || ((r_gcnt == 2'd1) && move);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gcnt   <= 2'd0;
            r_gidx   <= 2'd0;
            r_ovalid <= 1'b0;
            r_olast  <= 1'b0;
        end else begin
            if (move) begin
                r_ovalid <= 1'b1;
                r_olast  <= (r_gcnt == 2'd1);
                r_gcnt   <= r_gcnt - 2'd1;
                r_gidx   <= r_gidx + 2'd1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_load) begin
                r_gcnt <= i_grp.cnt;
                r_gidx <= 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= r_grp[r_gidx];
        end
        if (i_load) begin
            r_grp <= i_grp.res;
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_res    = r_out;
    assign o_last   = r_olast;

endmodule

// ===== sv/source_token_lexer_core.sv =====
// Streaming source lexer. Each input beat carries one source byte, or the end mark in tuser;
// the block returns tokens, decoded string bytes and at most one error as output beats, with
// tlast on the final beat caused by each input beat. A byte is accepted every cycle while the
// output keeps up: the lexer state is updated as each byte is accepted, and its results
// pass through a three-entry result group and then an output register before the first
// result of a byte appears. The output side delivers one beat per cycle while tready is high,
// so a byte that yields two results (or the end mark, up to three) holds the input until all
// of its results have left the result group. After the end token or an error every beat is
// accepted and gives no output until reset.
module source_token_lexer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // source_byte
    input  logic [0:0]  s_axis_tuser,   // is_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [stl_pkg::DATA_W-1:0] m_axis_tdata, // error_code, token_line, span_start,
                                                     // span_end, value
    output logic [6:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast    // last
);

    localparam int P = stl_pkg::POSITION_BITS;

    typedef enum logic [3:0] {
        M_BETWEEN, M_WORD, M_ZERO, M_DEC, M_HEX, M_OPER, M_LINECMT, M_BLOCKCMT,
        M_STRING, M_ESCAPE, M_HASH, M_AUSER, M_ACAPS, M_ADROP, M_DNAME, M_DCLOSE
    } t_mode;

    t_mode                   r_mode,    n_mode;
    logic [6:0]              r_pend,    n_pend;
    logic [63:0]             r_wprefix, n_wprefix;
    logic [3:0]              r_wlen,    n_wlen;
    logic [63:0]             r_acc,     n_acc;
    logic [P-1:0]            r_soff,    n_soff;
    logic [P-1:0]            r_sline,   n_sline;
    logic [P-1:0]            r_off,     n_off;
    logic [P-1:0]            r_line,    n_line;
    logic [15:0]             r_brace,   n_brace;
    logic [stl_pkg::TOP_W-1:0] r_top,   n_top;
    logic [15:0]             r_cnest,   n_cnest;
    logic [P-1:0]            r_slen,    n_slen;
    logic [3:0]              r_aidx,    n_aidx;
    logic                    r_halt,    n_halt;
    logic [15:0]             r_stack [stl_pkg::INTERP_DEPTH];
    logic                    n_push;

    stl_pkg::t_grp           grp;
    stl_pkg::t_res           out_res;
    logic                    acc;
    logic                    buf_ready;

    assign acc           = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = buf_ready;

    always_comb begin
        t_mode                               m;
        logic                                done;
        logic [1:0]                          cnt;
        stl_pkg::t_res [stl_pkg::RES_MAX-1:0] res;
        logic [7:0]                          c;
        logic [P-1:0]                        off1;
        logic [7:0]                          pk;
        logic [8:0]                          ev;
        logic [15:0]                         stack_top;
        logic [119:0]                        caps_sh;
        logic [47:0]                         short_sh;
        logic [7:0]                          ach;
        logic [3:0]                          alen;
        logic [3:0]                          aidx1;

        n_mode    = r_mode;
        n_pend    = r_pend;
        n_wprefix = r_wprefix;
        n_wlen    = r_wlen;
        n_acc     = r_acc;
        n_soff    = r_soff;
        n_sline   = r_sline;
        n_off     = r_off;
        n_line    = r_line;
        n_brace   = r_brace;
        n_top     = r_top;
        n_cnest   = r_cnest;
        n_slen    = r_slen;
        n_aidx    = r_aidx;
        n_halt    = r_halt;
        n_push    = 1'b0;
        res       = '0;
        cnt       = 2'd0;
        done      = 1'b0;
        m         = r_mode;
        c         = s_axis_tdata;
        off1      = stl_pkg::sat_inc(r_off);
        pk        = stl_pkg::pair_kind({1'b0, r_pend}, c);
        ev        = stl_pkg::escape_val(c);
        stack_top = r_stack[stl_pkg::IDX_W'(r_top - 1'b1)];
        caps_sh   = stl_pkg::ATTR_CAPS << {r_aidx, 3'b000};
        short_sh  = ((r_mode == M_AUSER) ? stl_pkg::ATTR_USER : stl_pkg::ATTR_DROP)
                    << {r_aidx, 3'b000};
        ach       = (r_mode == M_ACAPS) ? caps_sh[119:112] : short_sh[47:40];
        alen      = (r_mode == M_ACAPS) ? 4'd15 : 4'd6;
        aidx1     = r_aidx + 4'd1;

        if (!r_halt) begin
            if (s_axis_tuser[0]) begin
                done = 1'b0;
                case (r_mode)
                    M_WORD: begin
                        res[cnt] = stl_pkg::mk_res((r_wlen <= 4'd8) ?
                                   stl_pkg::word_kind(r_wprefix, r_wlen) : stl_pkg::KIND_IDENT,
                                   stl_pkg::ERR_NONE, r_sline, r_soff, r_off, 64'd0);
                        cnt = cnt + 2'd1;
                    end
                    M_ZERO, M_DEC, M_HEX: begin
                        res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_INT, stl_pkg::ERR_NONE,
                                   r_sline, r_soff, r_off, r_acc);
                        cnt = cnt + 2'd1;
                    end
                    M_OPER: begin
                        res[cnt] = stl_pkg::mk_res(stl_pkg::single_kind({1'b0, r_pend}),
                                   stl_pkg::ERR_NONE, r_sline, r_soff, r_off, 64'd0);
                        cnt = cnt + 2'd1;
                    end
                    M_STRING: begin
                        res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_ERROR, stl_pkg::ERR_OPEN_STR,
                                   r_sline, r_soff, r_off, 64'd0);
                        cnt = cnt + 2'd1;
                        done = 1'b1;
                    end
                    M_ESCAPE: begin
                        res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_ERROR, stl_pkg::ERR_ESCAPE,
                                   r_sline, r_soff, r_off, 64'd0);
                        cnt = cnt + 2'd1;
                        done = 1'b1;
                    end
                    M_HASH, M_AUSER, M_ACAPS, M_ADROP: begin
                        res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_ERROR, stl_pkg::ERR_ATTR,
                                   r_sline, r_soff, r_off, 64'd0);
                        cnt = cnt + 2'd1;
                        done = 1'b1;
                    end
                    M_DNAME, M_DCLOSE: begin
                        res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_ERROR, stl_pkg::ERR_DROP,
                                   r_sline, r_soff, r_off, 64'd0);
                        cnt = cnt + 2'd1;
                        done = 1'b1;
                    end
                    default: ;
                endcase
                if (!done) begin
                    res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_END, stl_pkg::ERR_NONE,
                               r_line, r_off, r_off, 64'd0);
                    cnt = cnt + 2'd1;
                    if (r_top != '0) begin
                        res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_ERROR,
                                   stl_pkg::ERR_OPEN_INTP, r_line, r_off, r_off, 64'd0);
                        cnt = cnt + 2'd1;
                    end
                end
                n_halt = 1'b1;
            end else begin
                n_off = off1;
                if (m == M_ZERO) begin
                    if (c == "x") begin
                        m    = M_HEX;
                        done = 1'b1;
                    end else begin
                        m = M_DEC;
                    end
                end

                // A byte that ends a pending token is seen again between tokens.
                if (!done) begin
                    case (m)
                        M_WORD: begin
                            if (stl_pkg::is_alpha(c) || stl_pkg::is_digit(c)) begin
                                if (r_wlen < 4'd8) n_wprefix = {r_wprefix[55:0], c};
                                if (r_wlen < 4'd15) n_wlen = r_wlen + 4'd1;
                                done = 1'b1;
                            end else begin
                                res[cnt] = stl_pkg::mk_res((r_wlen <= 4'd8) ?
                                    stl_pkg::word_kind(r_wprefix, r_wlen) : stl_pkg::KIND_IDENT,
                                    stl_pkg::ERR_NONE, r_sline, r_soff, r_off, 64'd0);
                                cnt = cnt + 2'd1;
                                m = M_BETWEEN;
                            end
                        end
                        M_DEC: begin
                            if (stl_pkg::is_digit(c)) begin
                                n_acc = (r_acc << 3) + (r_acc << 1) + {56'd0, c - 8'h30};
                                done = 1'b1;
                            end else if (c == "_") begin
                                done = 1'b1;
                            end else begin
                                res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_INT, stl_pkg::ERR_NONE,
                                           r_sline, r_soff, r_off, r_acc);
                                cnt = cnt + 2'd1;
                                m = M_BETWEEN;
                            end
                        end
                        M_HEX: begin
                            if (stl_pkg::is_hexd(c)) begin
                                n_acc = {r_acc[59:0], stl_pkg::hex_val(c)};
                                done = 1'b1;
                            end else if (c == "_") begin
                                done = 1'b1;
                            end else begin
                                res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_INT, stl_pkg::ERR_NONE,
                                           r_sline, r_soff, r_off, r_acc);
                                cnt = cnt + 2'd1;
                                m = M_BETWEEN;
                            end
                        end
                        M_OPER: begin
                            n_pend = '0;
                            done   = 1'b1;
                            if (r_pend == 7'h2F && c == "/") begin
                                m = M_LINECMT;
                            end else if (r_pend == 7'h2F && c == "*") begin
                                n_cnest = 16'd1;
                                m = M_BLOCKCMT;
                            end else if (pk[7]) begin
                                res[cnt] = stl_pkg::mk_res(pk[6:0], stl_pkg::ERR_NONE,
                                           r_sline, r_soff, off1, 64'd0);
                                cnt = cnt + 2'd1;
                                m = M_BETWEEN;
                            end else begin
                                res[cnt] = stl_pkg::mk_res(stl_pkg::single_kind({1'b0, r_pend}),
                                           stl_pkg::ERR_NONE, r_sline, r_soff, r_off, 64'd0);
                                cnt = cnt + 2'd1;
                                m = M_BETWEEN;
                                done = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end

                if (!done) begin
                    case (m)
                        M_BETWEEN: begin
                            if (c == " " || c == "\t" || c == "\r") begin
                                m = M_BETWEEN;
                            end else if (c == "\n") begin
                                n_line = stl_pkg::sat_inc(r_line);
                            end else if (stl_pkg::is_alpha(c)) begin
                                n_soff    = r_off;
                                n_sline   = r_line;
                                n_wprefix = {56'd0, c};
                                n_wlen    = 4'd1;
                                m         = M_WORD;
                            end else if (stl_pkg::is_digit(c)) begin
                                n_soff  = r_off;
                                n_sline = r_line;
                                n_acc   = {56'd0, c - 8'h30};
                                m       = (c == "0") ? M_ZERO : M_DEC;
                            end else if (c == "\"") begin
                                n_soff  = r_off;
                                n_sline = r_line;
                                n_slen  = '0;
                                n_pend  = '0;
                                m       = M_STRING;
                            end else if (c == "#") begin
                                n_soff  = r_off;
                                n_sline = r_line;
                                n_aidx  = 4'd0;
                                m       = M_HASH;
                            end else if (c == "{") begin
                                n_brace = r_brace + 16'd1;
                                res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_LBRACE,
                                           stl_pkg::ERR_NONE, r_line, r_off, off1, 64'd0);
                                cnt = cnt + 2'd1;
                            end else if (c == "}") begin
                                if (r_top != '0 && r_brace == stack_top) begin
                                    n_top   = r_top - 1'b1;
                                    res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_ICLOSE,
                                               stl_pkg::ERR_NONE, r_line, r_off, off1, 64'd0);
                                    cnt = cnt + 2'd1;
                                    n_soff  = off1;
                                    n_sline = r_line;
                                    n_slen  = '0;
                                    n_pend  = 7'd1;
                                    m       = M_STRING;
                                end else begin
                                    n_brace = r_brace - 16'd1;
                                    res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_RBRACE,
                                               stl_pkg::ERR_NONE, r_line, r_off, off1, 64'd0);
                                    cnt = cnt + 2'd1;
                                end
                            end else if (stl_pkg::is_pair_first(c)) begin
                                n_soff  = r_off;
                                n_sline = r_line;
                                n_pend  = c[6:0];
                                m       = M_OPER;
                            end else if (stl_pkg::single_kind(c) != stl_pkg::KIND_END) begin
                                res[cnt] = stl_pkg::mk_res(stl_pkg::single_kind(c),
                                           stl_pkg::ERR_NONE, r_line, r_off, off1, 64'd0);
                                cnt = cnt + 2'd1;
                            end else begin
                                res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_ERROR,
                                           stl_pkg::ERR_CHAR, r_line, r_off, off1, 64'd0);
                                cnt = cnt + 2'd1;
                                n_halt = 1'b1;
                            end
                        end
                        M_LINECMT: begin
                            if (c == "\n") begin
                                n_line = stl_pkg::sat_inc(r_line);
                                m = M_BETWEEN;
                            end
                        end
                        M_BLOCKCMT: begin
                            n_pend = '0;
                            if (r_pend == 7'h2F && c == "*") begin
                                if (r_cnest != 16'hFFFF) n_cnest = r_cnest + 16'd1;
                            end else if (r_pend == 7'h2A && c == "/") begin
                                if (r_cnest != 16'd0) n_cnest = r_cnest - 16'd1;
                                if (n_cnest == 16'd0) m = M_BETWEEN;
                            end else if (c == "/" || c == "*") begin
                                n_pend = c[6:0];
                            end else if (c == "\n") begin
                                n_line = stl_pkg::sat_inc(r_line);
                            end
                        end
                        M_STRING: begin
                            if (c == "\"") begin
                                res[cnt] = stl_pkg::mk_res((r_pend != '0) ?
                                           stl_pkg::KIND_TAIL : stl_pkg::KIND_STR,
                                           stl_pkg::ERR_NONE, r_sline, r_soff, off1,
                                           64'(r_slen));
                                cnt = cnt + 2'd1;
                                n_pend = '0;
                                m = M_BETWEEN;
                            end else if (c == "{") begin
                                if (r_top >= stl_pkg::TOP_W'(stl_pkg::INTERP_DEPTH)) begin
                                    res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_ERROR,
                                               stl_pkg::ERR_DEEP, r_sline, r_soff, off1, 64'd0);
                                    cnt = cnt + 2'd1;
                                    n_halt = 1'b1;
                                end else begin
                                    n_push = 1'b1;
                                    n_top  = r_top + 1'b1;
                                    res[cnt] = stl_pkg::mk_res((r_pend != '0) ?
                                               stl_pkg::KIND_MID : stl_pkg::KIND_HEAD,
                                               stl_pkg::ERR_NONE, r_sline, r_soff, off1,
                                               64'(r_slen));
                                    cnt = cnt + 2'd1;
                                    n_pend = '0;
                                    m = M_BETWEEN;
                                end
                            end else if (c == "\\") begin
                                m = M_ESCAPE;
                            end else begin
                                if (c == "\n") n_line = stl_pkg::sat_inc(r_line);
                                res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_BYTE, stl_pkg::ERR_NONE,
                                           r_sline, r_soff, off1, {56'd0, c});
                                cnt = cnt + 2'd1;
                                n_slen = stl_pkg::sat_inc(r_slen);
                            end
                        end
                        M_ESCAPE: begin
                            if (!ev[8]) begin
                                res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_ERROR,
                                           stl_pkg::ERR_ESCAPE, r_sline, r_soff, off1, 64'd0);
                                cnt = cnt + 2'd1;
                                n_halt = 1'b1;
                            end else begin
                                res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_BYTE, stl_pkg::ERR_NONE,
                                           r_sline, r_soff, off1, {56'd0, ev[7:0]});
                                cnt = cnt + 2'd1;
                                n_slen = stl_pkg::sat_inc(r_slen);
                                m = M_STRING;
                            end
                        end
                        M_HASH: begin
                            if (r_aidx == 4'd0 && c == "[") begin
                                n_aidx = 4'd1;
                            end else if (r_aidx == 4'd1 && (c == "u" || c == "c" || c == "d"))
                            begin
                                n_aidx = 4'd2;
                                m = (c == "u") ? M_AUSER : ((c == "c") ? M_ACAPS : M_ADROP);
                            end else begin
                                res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_ERROR,
                                           stl_pkg::ERR_ATTR, r_sline, r_soff, off1, 64'd0);
                                cnt = cnt + 2'd1;
                                n_halt = 1'b1;
                            end
                        end
                        M_AUSER, M_ACAPS, M_ADROP: begin
                            if (r_aidx >= alen || c != ach) begin
                                res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_ERROR,
                                           stl_pkg::ERR_ATTR, r_sline, r_soff, off1, 64'd0);
                                cnt = cnt + 2'd1;
                                n_halt = 1'b1;
                            end else begin
                                n_aidx = aidx1;
                                if (aidx1 == alen) begin
                                    if (m == M_ADROP) begin
                                        n_slen = '0;
                                        m = M_DNAME;
                                    end else begin
                                        res[cnt] = stl_pkg::mk_res((m == M_AUSER) ?
                                                   stl_pkg::KIND_AUSER : stl_pkg::KIND_ACAPS,
                                                   stl_pkg::ERR_NONE, r_sline, r_soff, off1,
                                                   64'd0);
                                        cnt = cnt + 2'd1;
                                        m = M_BETWEEN;
                                    end
                                end
                            end
                        end
                        M_DNAME: begin
                            if (stl_pkg::is_alpha(c) || stl_pkg::is_digit(c)) begin
                                n_slen = stl_pkg::sat_inc(r_slen);
                            end else if (c == ")" && r_slen != '0) begin
                                m = M_DCLOSE;
                            end else begin
                                res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_ERROR,
                                           stl_pkg::ERR_DROP, r_sline, r_soff, off1, 64'd0);
                                cnt = cnt + 2'd1;
                                n_halt = 1'b1;
                            end
                        end
                        M_DCLOSE: begin
                            if (c == "]") begin
                                res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_ADROP,
                                           stl_pkg::ERR_NONE, r_sline, r_soff, off1,
                                           64'(r_slen));
                                cnt = cnt + 2'd1;
                                m = M_BETWEEN;
                            end else begin
                                res[cnt] = stl_pkg::mk_res(stl_pkg::KIND_ERROR,
                                           stl_pkg::ERR_DROP, r_sline, r_soff, off1, 64'd0);
                                cnt = cnt + 2'd1;
                                n_halt = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                n_mode = m;
            end
        end

        grp.cnt = acc ? cnt : 2'd0;
        grp.res = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_BETWEEN;
            r_pend    <= '0;
            r_wprefix <= '0;
            r_wlen    <= '0;
            r_acc     <= '0;
            r_soff    <= '0;
            r_sline   <= P'(1);
            r_off     <= '0;
            r_line    <= P'(1);
            r_brace   <= '0;
            r_top     <= '0;
            r_cnest   <= '0;
            r_slen    <= '0;
            r_aidx    <= '0;
            r_halt    <= 1'b0;
        end else if (acc) begin
            r_mode    <= n_mode;
            r_pend    <= n_pend;
            r_wprefix <= n_wprefix;
            r_wlen    <= n_wlen;
            r_acc     <= n_acc;
            r_soff    <= n_soff;
            r_sline   <= n_sline;
            r_off     <= n_off;
            r_line    <= n_line;
            r_brace   <= n_brace;
            r_top     <= n_top;
            r_cnest   <= n_cnest;
            r_slen    <= n_slen;
            r_aidx    <= n_aidx;
            r_halt    <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && n_push) begin
            r_stack[r_top[stl_pkg::IDX_W-1:0]] <= r_brace;
        end
    end

    stl_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (acc),
        .i_grp    (grp),
        .o_ready  (buf_ready),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_res    (out_res),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = stl_pkg::DATA_W'({out_res.value, out_res.span_e, out_res.span_s,
                                            out_res.line, out_res.err});

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_halt) |-> (grp.cnt == 2'd0))
        else $error("results produced while halted");

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= stl_pkg::TOP_W'(stl_pkg::INTERP_DEPTH))
        else $error("interpolation stack overrun");

    a_comment_nest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_BLOCKCMT) |-> (r_cnest != 16'd0))
        else $error("block comment open with zero nesting");

endmodule

// ===== verif/source_token_lexer_core_tb.sv =====
`default_nettype none

module source_token_lexer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stl_pkg::*;

    localparam int P = POSITION_BITS;

    typedef enum logic [3:0] {
        LX_IDLE, LX_WORD, LX_ZERO, LX_DEC, LX_HEX, LX_OP, LX_LCMT, LX_BCMT,
        LX_STR, LX_ESC, LX_HASH, LX_AUSER, LX_ACAPS, LX_ADROP, LX_DNAME, LX_DCLOSE
    } lex_mode_e;

    typedef struct {
        logic [7:0] b;
        bit         e;
        bit         typed;
        logic [6:0] kind;
    } src_item_t;

    typedef struct {
        t_res r;
        bit   last;
    } token_beat_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = '0;
    logic [0:0]          s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [DATA_W-1:0]   m_axis_tdata;  // error_code, token_line, span_start, span_end, value
    logic [6:0]          m_axis_tuser;  // kind
    logic                m_axis_tlast;

    source_token_lexer_core u_top (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Lexer state mirrored by the predictor.
    lex_mode_e     lx_mode;
    logic [7:0]    lx_pend;
    logic [63:0]   lx_prefix;
    int            lx_wlen;
    logic [63:0]   lx_acc;
    logic [P-1:0]  lx_tok_s, lx_tok_line, lx_pos, lx_line, lx_slen;
    logic [15:0]   lx_braces;
    logic [15:0]   lx_istack [INTERP_DEPTH];
    int            lx_itop;
    int            lx_cnest;
    int            lx_aidx;
    bit            lx_halt;

    t_res          batch [RES_MAX];
    int            batch_n;

    token_beat_t   beat_q [$];
    src_item_t     src_q [$];
    int            fail_cnt;
    int            beats_seen;
    int            bytes_sent;
    bit            long_hold_req;

    string kw_text [22] = '{"extern", "syscall", "fn", "mut", "return", "if", "else", "while",
                            "break", "continue", "as", "raw", "true", "false", "struct",
                            "defer", "enum", "match", "impl", "for", "in", "own"};
    byte   kw_code [22] = '{8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20, 21, 22, 23,
                            24, 25, 27, 28, 29, 36};

    function automatic logic [P-1:0] bump(input logic [P-1:0] x);
        return (x == POS_MAX) ? x : x + 1'b1;
    endfunction

    function automatic bit alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit hexdig(input logic [7:0] c);
        return digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [63:0] hexv(input logic [7:0] c);
        return digit(c) ? 64'(c - 8'd48) : 64'((c | 8'h20) - 8'd87);
    endfunction

    function automatic logic [6:0] one_kind(input logic [7:0] c);
        case (c)
            "(": return 7'd37;  ")": return 7'd38;  ",": return 7'd41;  ";": return 7'd42;
            "[": return 7'd34;  "]": return 7'd35;  "?": return 7'd69;  "^": return 7'd65;
            "%": return 7'd51;  "*": return 7'd49;  "/": return 7'd50;  ".": return 7'd68;
            ":": return 7'd43;  "-": return 7'd48;  "+": return 7'd47;  "=": return 7'd46;
            "!": return 7'd60;  "<": return 7'd56;  ">": return 7'd58;  "&": return 7'd63;
            "|": return 7'd64;
            default: return KIND_END;
        endcase
    endfunction

    function automatic bit pair_first(input logic [7:0] c);
        return c == "." || c == ":" || c == "-" || c == "+" || c == "=" || c == "!" ||
               c == "<" || c == ">" || c == "&" || c == "|" || c == "/";
    endfunction

    function automatic int pair_code(input logic [7:0] f, input logic [7:0] c);
        case ({f, c})
            {".", "."}: return 30;  {":", "="}: return 44;  {"-", ">"}: return 45;
            {"-", "="}: return 53;  {"+", "="}: return 52;  {"=", "="}: return 54;
            {"=", ">"}: return 26;  {"!", "="}: return 55;  {"<", "="}: return 57;
            {"<", "<"}: return 66;  {">", "="}: return 59;  {">", ">"}: return 67;
            {"&", "&"}: return 61;  {"|", "|"}: return 62;
            default: return -1;
        endcase
    endfunction

    function automatic int unescape(input logic [7:0] c);
        case (c)
            "n": return 10;
            "t": return 9;
            "r": return 13;
            "0": return 0;
            "\\", "\"", "'", "{", "}": return int'(c);
            default: return -1;
        endcase
    endfunction

    function automatic void put(input logic [6:0] k, input logic [2:0] err,
                                input logic [P-1:0] ln, input logic [P-1:0] s,
                                input logic [P-1:0] e, input logic [63:0] v);
        if (batch_n < RES_MAX) begin
            batch[batch_n].kind   = k;
            batch[batch_n].err    = err;
            batch[batch_n].line   = ln;
            batch[batch_n].span_s = s;
            batch[batch_n].span_e = e;
            batch[batch_n].value  = v;
            batch_n++;
        end
    endfunction

    function automatic void abort(input logic [2:0] code, input logic [P-1:0] ln,
                                  input logic [P-1:0] s, input logic [P-1:0] e);
        put(KIND_ERROR, code, ln, s, e, 64'd0);
        lx_halt = 1'b1;
    endfunction

    function automatic void mark_token();
        lx_tok_s    = lx_pos;
        lx_tok_line = lx_line;
    endfunction

    function automatic void word_token();
        logic [6:0]  k;
        logic [63:0] p;
        k = KIND_IDENT;
        if (lx_wlen <= 8) begin
            for (int i = 0; i < 22; i++) begin
                p = '0;
                for (int j = 0; j < kw_text[i].len(); j++) p = (p << 8) | 64'(kw_text[i][j]);
                if (kw_text[i].len() == lx_wlen && p == lx_prefix) begin
                    k = 7'(kw_code[i]);
                    break;
                end
            end
        end
        put(k, ERR_NONE, lx_tok_line, lx_tok_s, lx_pos, 64'd0);
    endfunction

    function automatic void str_byte(input logic [7:0] v);
        put(KIND_BYTE, ERR_NONE, lx_tok_line, lx_tok_s, bump(lx_pos), 64'(v));
        lx_slen = bump(lx_slen);
    endfunction

    // Returns 1 when the byte ends the current token and must be scanned again.
    function automatic bit lex_byte(input logic [7:0] c);
        logic [7:0] p;
        int         pk;
        string      pat;
        case (lx_mode)
            LX_IDLE: begin
                if (c == " " || c == "\t" || c == "\r") return 0;
                if (c == "\n") begin
                    lx_line = bump(lx_line);
                    return 0;
                end
                if (alpha(c)) begin
                    mark_token();
                    lx_prefix = 64'(c);
                    lx_wlen = 1;
                    lx_mode = LX_WORD;
                    return 0;
                end
                if (digit(c)) begin
                    mark_token();
                    lx_acc = 64'(c - 8'd48);
                    lx_mode = (c == "0") ? LX_ZERO : LX_DEC;
                    return 0;
                end
                if (c == "\"") begin
                    mark_token();
                    lx_slen = '0;
                    lx_pend = '0;
                    lx_mode = LX_STR;
                    return 0;
                end
                if (c == "#") begin
                    mark_token();
                    lx_aidx = 0;
                    lx_mode = LX_HASH;
                    return 0;
                end
                if (c == "{") begin
                    lx_braces++;
                    put(KIND_LBRACE, ERR_NONE, lx_line, lx_pos, bump(lx_pos), 64'd0);
                    return 0;
                end
                if (c == "}") begin
                    if (lx_itop > 0 && lx_braces == lx_istack[lx_itop-1]) begin
                        lx_itop--;
                        put(KIND_ICLOSE, ERR_NONE, lx_line, lx_pos, bump(lx_pos), 64'd0);
                        lx_tok_s    = bump(lx_pos);
                        lx_tok_line = lx_line;
                        lx_slen     = '0;
                        lx_pend     = 8'd1;
                        lx_mode     = LX_STR;
                    end else begin
                        lx_braces--;
                        put(KIND_RBRACE, ERR_NONE, lx_line, lx_pos, bump(lx_pos), 64'd0);
                    end
                    return 0;
                end
                if (pair_first(c)) begin
                    mark_token();
                    lx_pend = c;
                    lx_mode = LX_OP;
                    return 0;
                end
                if (one_kind(c) != KIND_END) begin
                    put(one_kind(c), ERR_NONE, lx_line, lx_pos, bump(lx_pos), 64'd0);
                    return 0;
                end
                abort(ERR_CHAR, lx_line, lx_pos, bump(lx_pos));
                return 0;
            end
            LX_WORD: begin
                if (alpha(c) || digit(c)) begin
                    if (lx_wlen < 8) lx_prefix = (lx_prefix << 8) | 64'(c);
                    if (lx_wlen < 15) lx_wlen++;
                    return 0;
                end
                word_token();
                lx_mode = LX_IDLE;
                return 1;
            end
            LX_ZERO: begin
                if (c == "x") begin
                    lx_mode = LX_HEX;
                    return 0;
                end
                lx_mode = LX_DEC;
                return 1;
            end
            LX_DEC, LX_HEX: begin
                if (lx_mode == LX_DEC && digit(c)) begin
                    lx_acc = lx_acc * 64'd10 + 64'(c - 8'd48);
                    return 0;
                end
                if (lx_mode == LX_HEX && hexdig(c)) begin
                    lx_acc = lx_acc * 64'd16 + hexv(c);
                    return 0;
                end
                if (c == "_") return 0;
                put(KIND_INT, ERR_NONE, lx_tok_line, lx_tok_s, lx_pos, lx_acc);
                lx_mode = LX_IDLE;
                return 1;
            end
            LX_OP: begin
                p = lx_pend;
                lx_pend = '0;
                if (p == "/" && c == "/") begin
                    lx_mode = LX_LCMT;
                    return 0;
                end
                if (p == "/" && c == "*") begin
                    lx_cnest = 1;
                    lx_mode = LX_BCMT;
                    return 0;
                end
                pk = pair_code(p, c);
                lx_mode = LX_IDLE;
                if (pk >= 0) begin
                    put(7'(pk), ERR_NONE, lx_tok_line, lx_tok_s, bump(lx_pos), 64'd0);
                    return 0;
                end
                put(one_kind(p), ERR_NONE, lx_tok_line, lx_tok_s, lx_pos, 64'd0);
                return 1;
            end
            LX_LCMT: begin
                if (c == "\n") begin
                    lx_line = bump(lx_line);
                    lx_mode = LX_IDLE;
                end
                return 0;
            end
            LX_BCMT: begin
                p = lx_pend;
                lx_pend = '0;
                if (p == "/" && c == "*") begin
                    if (lx_cnest < 65535) lx_cnest++;
                    return 0;
                end
                if (p == "*" && c == "/") begin
                    if (lx_cnest > 0) lx_cnest--;
                    if (lx_cnest == 0) lx_mode = LX_IDLE;
                    return 0;
                end
                if (c == "/" || c == "*") lx_pend = c;
                else if (c == "\n") lx_line = bump(lx_line);
                return 0;
            end
            LX_STR: begin
                if (c == "\"") begin
                    put((lx_pend != 0) ? KIND_TAIL : KIND_STR, ERR_NONE, lx_tok_line, lx_tok_s,
                        bump(lx_pos), 64'(lx_slen));
                    lx_pend = '0;
                    lx_mode = LX_IDLE;
                    return 0;
                end
                if (c == "{") begin
                    if (lx_itop >= INTERP_DEPTH) begin
                        abort(ERR_DEEP, lx_tok_line, lx_tok_s, bump(lx_pos));
                        return 0;
                    end
                    lx_istack[lx_itop] = lx_braces;
                    lx_itop++;
                    put((lx_pend != 0) ? KIND_MID : KIND_HEAD, ERR_NONE, lx_tok_line, lx_tok_s,
                        bump(lx_pos), 64'(lx_slen));
                    lx_pend = '0;
                    lx_mode = LX_IDLE;
                    return 0;
                end
                if (c == "\\") begin
                    lx_mode = LX_ESC;
                    return 0;
                end
                if (c == "\n") lx_line = bump(lx_line);
                str_byte(c);
                return 0;
            end
            LX_ESC: begin
                pk = unescape(c);
                if (pk < 0) begin
                    abort(ERR_ESCAPE, lx_tok_line, lx_tok_s, bump(lx_pos));
                    return 0;
                end
                str_byte(8'(pk));
                lx_mode = LX_STR;
                return 0;
            end
            LX_HASH: begin
                if (lx_aidx == 0 && c == "[") begin
                    lx_aidx = 1;
                    return 0;
                end
                if (lx_aidx == 1) begin
                    if (c == "u") lx_mode = LX_AUSER;
                    else if (c == "c") lx_mode = LX_ACAPS;
                    else if (c == "d") lx_mode = LX_ADROP;
                    if (lx_mode != LX_HASH) begin
                        lx_aidx = 2;
                        return 0;
                    end
                end
                abort(ERR_ATTR, lx_tok_line, lx_tok_s, bump(lx_pos));
                return 0;
            end
            LX_AUSER, LX_ACAPS, LX_ADROP: begin
                pat = (lx_mode == LX_AUSER) ? "[user]" :
                      (lx_mode == LX_ACAPS) ? "[caps(syscall)]" : "[drop(";
                if (lx_aidx >= pat.len() || c != pat[lx_aidx]) begin
                    abort(ERR_ATTR, lx_tok_line, lx_tok_s, bump(lx_pos));
                    return 0;
                end
                lx_aidx++;
                if (lx_aidx == pat.len()) begin
                    if (lx_mode == LX_ADROP) begin
                        lx_slen = '0;
                        lx_mode = LX_DNAME;
                        return 0;
                    end
                    put((lx_mode == LX_AUSER) ? KIND_AUSER : KIND_ACAPS, ERR_NONE, lx_tok_line,
                        lx_tok_s, bump(lx_pos), 64'd0);
                    lx_mode = LX_IDLE;
                end
                return 0;
            end
            LX_DNAME: begin
                if (alpha(c) || digit(c)) begin
                    lx_slen = bump(lx_slen);
                    return 0;
                end
                if (c == ")" && lx_slen != 0) begin
                    lx_mode = LX_DCLOSE;
                    return 0;
                end
                abort(ERR_DROP, lx_tok_line, lx_tok_s, bump(lx_pos));
                return 0;
            end
            default: begin
                if (c == "]") begin
                    put(KIND_ADROP, ERR_NONE, lx_tok_line, lx_tok_s, bump(lx_pos), 64'(lx_slen));
                    lx_mode = LX_IDLE;
                    return 0;
                end
                abort(ERR_DROP, lx_tok_line, lx_tok_s, bump(lx_pos));
                return 0;
            end
        endcase
    endfunction

    function automatic void lex_end();
        case (lx_mode)
            LX_WORD: word_token();
            LX_ZERO, LX_DEC, LX_HEX:
                put(KIND_INT, ERR_NONE, lx_tok_line, lx_tok_s, lx_pos, lx_acc);
            LX_OP: put(one_kind(lx_pend), ERR_NONE, lx_tok_line, lx_tok_s, lx_pos, 64'd0);
            LX_STR: begin
                abort(ERR_OPEN_STR, lx_tok_line, lx_tok_s, lx_pos);
                return;
            end
            LX_ESC: begin
                abort(ERR_ESCAPE, lx_tok_line, lx_tok_s, lx_pos);
                return;
            end
            LX_HASH, LX_AUSER, LX_ACAPS, LX_ADROP: begin
                abort(ERR_ATTR, lx_tok_line, lx_tok_s, lx_pos);
                return;
            end
            LX_DNAME, LX_DCLOSE: begin
                abort(ERR_DROP, lx_tok_line, lx_tok_s, lx_pos);
                return;
            end
            default: ;
        endcase
        put(KIND_END, ERR_NONE, lx_line, lx_pos, lx_pos, 64'd0);
        lx_halt = 1'b1;
        if (lx_itop > 0) abort(ERR_OPEN_INTP, lx_line, lx_pos, lx_pos);
    endfunction

    function automatic void lex_step(input src_item_t it);
        int guard;
        batch_n = 0;
        if (lx_halt) return;
        if (it.e) begin
            lex_end();
        end else begin
            guard = 0;
            while (lex_byte(it.b) && !lx_halt && guard < 4) guard++;
            lx_pos = bump(lx_pos);
        end
        if (it.typed && batch_n > 0) batch[0].kind = it.kind;
        for (int i = 0; i < batch_n; i++) beat_q.push_back('{batch[i], i == batch_n - 1});
    endfunction

    // Source text construction.
    function automatic void add_byte(input logic [7:0] b);
        src_q.push_back('{b, 1'b0, 1'b0, KIND_END});
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic void add_sep();
        string seps = "    \t\n\r";
        add_byte(seps[$urandom_range(0, seps.len() - 1)]);
    endfunction

    function automatic void add_ident();
        string head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        string tail = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        int n = $urandom_range(1, 12);
        add_byte(head[$urandom_range(0, head.len() - 1)]);
        for (int i = 1; i < n; i++) add_byte(tail[$urandom_range(0, tail.len() - 1)]);
    endfunction

    function automatic void add_number();
        string hx = "0123456789abcdefABCDEF";
        bit is_hex = $urandom_range(0, 1);
        int n = $urandom_range(1, 22);
        if (is_hex) add_text("0x");
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) add_byte("_");
            add_byte(is_hex ? hx[$urandom_range(0, hx.len() - 1)] : 8'($urandom_range(48, 57)));
        end
    endfunction

    function automatic void add_str_body();
        string esc = "ntr0\\\"'{}";
        int n = $urandom_range(0, 10);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                add_byte("\\");
                add_byte(esc[$urandom_range(0, esc.len() - 1)]);
            end else begin
                do b = 8'($urandom_range(0, 255)); while (b == "\"" || b == "\\" || b == "{");
                add_byte(b);
            end
        end
    endfunction

    function automatic void add_fragment();
        string ops [34] = '{"(", ")", ",", ";", "[", "]", "?", "^", "%", "*", "/", ".", ":",
                            "-", "+", "=", "!", "<", ">", "&", "|", "..", ":=", "->", "-=",
                            "+=", "==", "=>", "!=", "<=", "<<", ">=", ">>", "&&"};
        string words = "abc x \n";
        int depth;
        case ($urandom_range(0, 12))
            0, 1: add_text(kw_text[$urandom_range(0, 21)]);
            2: add_ident();
            3, 4: add_number();
            5: add_text(($urandom_range(0, 5) == 0) ? "||" : ops[$urandom_range(0, 33)]);
            6: begin
                add_byte("\"");
                add_str_body();
                add_byte("\"");
            end
            7: begin
                add_byte("\"");
                repeat ($urandom_range(1, 2)) begin
                    add_str_body();
                    add_byte("{");
                    add_sep();
                    if ($urandom_range(0, 2) == 0) add_text("{ x } ");
                    add_ident();
                    add_sep();
                    add_number();
                    add_byte("}");
                end
                add_str_body();
                add_byte("\"");
            end
            8: begin
                add_text("//");
                repeat ($urandom_range(0, 8)) add_byte(($urandom_range(0, 1)) ?
                                                       8'($urandom_range(0, 9)) : 8'h41);
                add_byte("\n");
            end
            9: begin
                depth = $urandom_range(1, 3);
                repeat (depth) begin
                    add_text("/*");
                    add_byte(words[$urandom_range(0, words.len() - 1)]);
                end
                repeat (depth) begin
                    add_byte(words[$urandom_range(0, words.len() - 1)]);
                    add_text(($urandom_range(0, 3) == 0) ? "**/" : "*/");
                end
            end
            10: add_text(($urandom_range(0, 1)) ? "#[user]" : "#[caps(syscall)]");
            11: begin
                add_text("#[drop(");
                add_ident();
                add_text(")]");
            end
            default: begin
                add_text("{ ");
                add_ident();
                add_text(" }");
            end
        endcase
        add_sep();
    endfunction

    function automatic void add_ending();
        case ($urandom_range(0, 11))
            0: ;
            1: add_ident();
            2: add_text("\"ab");
            3: add_text("\"a\\");
            4: add_text("\"a\\q \"");
            5: repeat (INTERP_DEPTH + 1) add_text("\"{");
            6: add_text("#[x]");
            7: add_text("#[drop()]");
            8: add_text("$ ");
            9: add_text("\"a{ x ");
            10: add_text("/* open");
            default: add_text("0x1F");
        endcase
        add_text(" z ");
        src_q.push_back('{8'hFF, 1'b1, 1'b0, KIND_END});
    endfunction

    function automatic void build_source();
        src_item_t warmup [22] = '{
            '{"{", 0, 1, KIND_LBRACE}, '{"}", 0, 1, KIND_RBRACE}, '{"(", 0, 0, KIND_END},
            '{";", 0, 0, KIND_END}, '{"?", 0, 0, KIND_END}, '{" ", 0, 0, KIND_END},
            '{"\"", 0, 0, KIND_END}, '{8'h00, 0, 1, KIND_BYTE}, '{8'hFF, 0, 1, KIND_BYTE},
            '{"\\", 0, 0, KIND_END}, '{"n", 0, 0, KIND_END}, '{"\"", 0, 0, KIND_END},
            '{" ", 0, 0, KIND_END}, '{"x", 0, 0, KIND_END}, '{"+", 0, 0, KIND_END},
            '{"=", 0, 0, KIND_END}, '{"0", 0, 0, KIND_END}, '{"x", 0, 0, KIND_END},
            '{"_", 0, 0, KIND_END}, '{"F", 0, 0, KIND_END}, '{"\t", 0, 0, KIND_END},
            '{"\n", 0, 0, KIND_END}};
        foreach (warmup[i]) src_q.push_back(warmup[i]);
        while (src_q.size() < 300) add_fragment();
        add_ending();
    endfunction

    // Output side: checks every beat and applies back-pressure.
    initial begin : receiver
        token_beat_t exp_b;
        logic [2:0]  got_err;
        logic [P-1:0] got_line, got_s, got_e;
        logic [63:0] got_val;
        int          hold;
        int          cyc;
        hold = 0;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (m_axis_tvalid && m_axis_tready) begin
                beats_seen++;
                got_err  = m_axis_tdata[2:0];
                got_line = m_axis_tdata[3 +: P];
                got_s    = m_axis_tdata[3 + P +: P];
                got_e    = m_axis_tdata[3 + 2*P +: P];
                got_val  = m_axis_tdata[3 + 3*P +: 64];
                if (beat_q.size() == 0) begin
                    $error("unexpected beat: kind %0d", m_axis_tuser);
                    fail_cnt++;
                end else begin
                    exp_b = beat_q.pop_front();
                    if (m_axis_tuser !== exp_b.r.kind) begin
                        $error("kind: expected %0d, got %0d", exp_b.r.kind, m_axis_tuser);
                        fail_cnt++;
                    end
                    if (got_err !== exp_b.r.err) begin
                        $error("error_code: expected %0d, got %0d", exp_b.r.err, got_err);
                        fail_cnt++;
                    end
                    if (got_line !== exp_b.r.line) begin
                        $error("token_line: expected %0d, got %0d", exp_b.r.line, got_line);
                        fail_cnt++;
                    end
                    if (got_s !== exp_b.r.span_s) begin
                        $error("span_start: expected %0d, got %0d", exp_b.r.span_s, got_s);
                        fail_cnt++;
                    end
                    if (got_e !== exp_b.r.span_e) begin
                        $error("span_end: expected %0d, got %0d", exp_b.r.span_e, got_e);
                        fail_cnt++;
                    end
                    if (got_val !== exp_b.r.value) begin
                        $error("value: expected %0h, got %0h", exp_b.r.value, got_val);
                        fail_cnt++;
                    end
                    if (m_axis_tlast !== exp_b.last) begin
                        $error("last: expected %0b, got %0b", exp_b.last, m_axis_tlast);
                        fail_cnt++;
                    end
                end
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = 300;
            end else if (hold == 0 && (cyc / 200) % 2 == 1 && $urandom_range(0, 15) == 0) begin
                hold = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
            else idle++;
            if (idle >= 3000) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin : sender
        int gap;
        bit quiet;
        fail_cnt = 0;
        beats_seen = 0;
        bytes_sent = 0;
        long_hold_req = 1'b0;
        lx_mode = LX_IDLE;  lx_pend = '0;  lx_prefix = '0;  lx_wlen = 0;  lx_acc = '0;
        lx_tok_s = '0;  lx_tok_line = 1;  lx_pos = '0;  lx_line = 1;  lx_braces = '0;
        lx_itop = 0;  lx_cnest = 0;  lx_slen = '0;  lx_aidx = 0;  lx_halt = 1'b0;
        build_source();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        quiet = 1'b0;
        foreach (src_q[n]) begin
            if (n % 50 == 0) quiet = $urandom_range(0, 2) == 0;
            if (n == 120) long_hold_req = 1'b1;
            if (n == 200) begin
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (beat_q.size() != 0);
            end
            gap = 0;
            if (!quiet && $urandom_range(0, 9) >= 7)
                gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= src_q[n].b;
            s_axis_tuser  <= src_q[n].e;
            do @(posedge i_clk); while (!s_axis_tready);
            bytes_sent++;
            lex_step(src_q[n]);
        end
        s_axis_tvalid <= 1'b0;
        while (beat_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        $display("Lexed %0d input beats of mixed source text, %0d output beats compared.",
                 bytes_sent, beats_seen);
        if (fail_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/stl_pkg.sv
sv/stl_out_buf.sv
sv/source_token_lexer_core.sv
verif/source_token_lexer_core_tb.sv
